/* rtl/core/hec_pkg.sv */
package hec_pkg;

  localparam int unsigned MAX_PIXELS = 65536;
  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned ENT_W = 16;
  localparam int unsigned TOT_W = 17;

  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned MANT_W    = 31;
  localparam int unsigned QUO_W     = 18;
  localparam int unsigned Q15_ONE   = 32768;
  localparam int unsigned SHARE_DIV = 1000000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             counted;
  } hec_entry_t;

  typedef struct packed {
    logic clearing;
  } hec_stat_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_ACC,
    S_LN_GO,
    S_LN_WT,
    S_RD,
    S_CHK,
    S_LG_WT,
    S_MUL,
    S_ADD,
    S_DVI,
    S_DIV,
    S_OUT
  } hec_back_state_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } hec_lg_state_e;

endpackage

/* rtl/core/hec_if.sv */
interface hec_pix_if import hec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

interface hec_res_if import hec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ENT_W-1:0] entropy_norm;
  logic [TOT_W-1:0] pixel_total;
  logic             count_overflow;

  modport source (output valid, output entropy_norm, output pixel_total,
                  output count_overflow, input ready);
  modport sink (input valid, input entropy_norm, input pixel_total,
                input count_overflow, output ready);
endinterface

/* rtl/core/histogram_entropy_core.sv */
// Pixels: one word per cycle unless the queue is full or clearing runs, into a 4-deep queue;
// histogram update reads a bin, then writes it back. Region result: after the last pixel,
// log2(N), then each bin is read and checked, a kept count adds its log2 term, then a divide.
// The bin pass is bounded by one shared log2 unit; the next region waits in the queue.
// Reset: clearing pass over all 256 bins of the bin memory, pixel input not ready meanwhile.
module histogram_entropy_core import hec_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS,
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input logic       clk_i,
  input logic       rst_ni,
  hec_pix_if.sink   pix_i,
  hec_res_if.source res_o
);

  hec_stat_t  stat;
  logic       full, push, pop, q_valid;
  hec_entry_t push_entry, q_entry;

  hec_front #(
    .MaxPixels(MaxPixels)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .stat_i (stat),
    .full_i (full),
    .push_o (push),
    .entry_o(push_entry)
  );

  hec_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  hec_back #(
    .MaxPixels(MaxPixels)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_entry_i(q_entry),
    .pop_o    (pop),
    .stat_o   (stat),
    .res_o    (res_o)
  );

endmodule

/* rtl/core/hec_front.sv */
module hec_front import hec_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hec_pix_if.sink    pix_i,
  input  hec_stat_t  stat_i,
  input  logic       full_i,
  output logic       push_o,
  output hec_entry_t entry_o
);

  localparam int unsigned CW = $clog2(MaxPixels + 1);

  logic [CW-1:0] seen_q, seen_d;
  logic          acc;
  logic          counted;

  assign pix_i.ready = !full_i && !stat_i.clearing;
  assign acc         = pix_i.valid && pix_i.ready;
  assign counted     = seen_q < CW'(MaxPixels);

  assign push_o          = acc;
  assign entry_o.pixel   = pix_i.pixel;
  assign entry_o.last    = pix_i.last_pixel;
  assign entry_o.counted = counted;

  always_comb begin
    seen_d = seen_q;
    if (acc) begin
      if (pix_i.last_pixel) begin
        seen_d = '0;
      end else if (counted) begin
        seen_d = seen_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

/* rtl/core/hec_fifo.sv */
module hec_fifo import hec_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hec_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output hec_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hec_entry_t      slot_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign entry_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/core/hec_log2.sv */
module hec_log2 import hec_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [$clog2(MaxPixels + 1)-1:0]             x_i,
  output logic                                         done_o,
  output logic [((($clog2(MaxPixels + 1)) > 1) ?
                 $clog2($clog2(MaxPixels + 1)) : 1) + FRAC_W - 1:0] res_o
);

  localparam int unsigned CW  = $clog2(MaxPixels + 1);
  localparam int unsigned EW  = (CW > 1) ? $clog2(CW) : 1;
  localparam int unsigned ICW = $clog2(FRAC_W);

  hec_lg_state_e       state_q, state_d;
  logic [ICW-1:0]      cnt_q;
  logic                done_q;
  logic [CW-1:0]       x_q;
  logic [EW-1:0]       e_q;
  logic [MANT_W-1:0]   m_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_top;
  logic                last_it;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LG_IDLE: if (start_i) state_d = LG_NORM;
      LG_NORM: if (x_q[CW-1]) state_d = LG_SQ;
      LG_SQ:   if (last_it) state_d = LG_IDLE;
      default: state_d = LG_IDLE;
    endcase
  end

  always_comb begin
    sq      = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
    sq_top  = sq[2*MANT_W-1:MANT_W-1];
    last_it = cnt_q == ICW'(FRAC_W - 1);
    done_o  = done_q;
    res_o   = {e_q, frac_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == LG_SQ) && last_it;
      if (state_q == LG_SQ) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          x_q <= x_i;
          e_q <= EW'(CW - 1);
        end
      end
      LG_NORM: begin
        if (x_q[CW-1]) begin
          m_q    <= MANT_W'(x_q) << (MANT_W - CW);
          frac_q <= '0;
        end else begin
          x_q <= x_q << 1;
          e_q <= e_q - 1'b1;
        end
      end
      LG_SQ: begin
        if (sq_top[MANT_W]) begin
          m_q    <= sq_top[MANT_W:1];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          m_q    <= sq_top[MANT_W-1:0];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/hec_back.sv */
module hec_back import hec_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  hec_entry_t q_entry_i,
  output logic       pop_o,
  output hec_stat_t  stat_o,
  hec_res_if.source  res_o
);

  localparam int unsigned CW  = $clog2(MaxPixels + 1);
  localparam int unsigned EW  = (CW > 1) ? $clog2(CW) : 1;
  localparam int unsigned LW  = EW + FRAC_W;
  localparam int unsigned PW  = CW + LW;
  localparam int unsigned TW  = CW + 22;
  localparam int unsigned MW  = CW + 20;
  localparam int unsigned BW  = $clog2(NUM_BINS);
  localparam int unsigned QCW = $clog2(QUO_W);

  hec_back_state_e state_q, state_d;

  logic [CW-1:0]    mem_q [NUM_BINS];
  logic [CW-1:0]    rd_q;
  logic             we;
  logic [BW-1:0]    wa, ra;
  logic [CW-1:0]    wd;
  logic             fwd_vld_q;
  logic [BW-1:0]    fwd_addr_q;
  logic [CW-1:0]    fwd_data_q;
  logic             s1_vld_q;
  logic [BW-1:0]    s1_addr_q;
  logic [CW-1:0]    cur, inc;

  logic [BW-1:0]    bin_q;
  logic             last_bin;
  logic [CW-1:0]    n_q;
  logic             ovf_q;
  logic [QCW-1:0]   qcnt_q;
  logic             out_vld_q;
  logic             load;

  logic [CW-1:0]    c_q;
  logic [LW-1:0]    ln_q, diff_q;
  logic [PW-1:0]    prod_q;
  logic [TW-1:0]    tot_q, rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic             ge;
  logic [MW-1:0]    cm;
  logic             keep;

  logic             lg_start, lg_done;
  logic [CW-1:0]    lg_x;
  logic [LW-1:0]    lg_res;

  logic [ENT_W-1:0] ent_q;
  logic [TOT_W-1:0] tot_out_q;
  logic             ovf_out_q;
  logic [CW+TOT_W-1:0] n_ext;

  hec_log2 #(
    .MaxPixels(MaxPixels)
  ) u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lg_start),
    .x_i    (lg_x),
    .done_o (lg_done),
    .res_o  (lg_res)
  );

  assign cur      = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_q;
  assign inc      = cur + 1'b1;
  assign cm       = MW'(rd_q) * MW'(SHARE_DIV);
  assign keep     = (rd_q != '0) && (cm > MW'(n_q));
  assign last_bin = bin_q == BW'(NUM_BINS - 1);
  assign ge       = rem_q >= dsh_q;
  assign load     = (state_q == S_OUT) && (!out_vld_q || res_o.ready);
  assign n_ext    = (CW + TOT_W)'(n_q);

  assign stat_o.clearing     = state_q == S_CLR;
  assign res_o.valid          = out_vld_q;
  assign res_o.entropy_norm   = ent_q;
  assign res_o.pixel_total    = tot_out_q;
  assign res_o.count_overflow = ovf_out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (last_bin) state_d = S_ACC;
      S_ACC:   if (q_valid_i && q_entry_i.last) state_d = S_LN_GO;
      S_LN_GO: state_d = S_LN_WT;
      S_LN_WT: if (lg_done) state_d = S_RD;
      S_RD:    state_d = S_CHK;
      S_CHK: begin
        if (keep) begin
          state_d = S_LG_WT;
        end else begin
          state_d = last_bin ? S_DVI : S_RD;
        end
      end
      S_LG_WT: if (lg_done) state_d = S_MUL;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = last_bin ? S_DVI : S_RD;
      S_DVI:   state_d = S_DIV;
      S_DIV:   if (qcnt_q == QCW'(QUO_W - 1)) state_d = S_OUT;
      S_OUT:   if (load) state_d = S_ACC;
      default: state_d = S_CLR;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    wa       = bin_q;
    wd       = '0;
    ra       = bin_q;
    pop_o    = 1'b0;
    lg_start = 1'b0;
    lg_x     = rd_q;
    if (s1_vld_q) begin
      we = 1'b1;
      wa = s1_addr_q;
      wd = inc;
    end
    unique case (state_q)
      S_CLR: we = 1'b1;
      S_ACC: begin
        pop_o = q_valid_i;
        ra    = q_entry_i.pixel;
      end
      S_LN_GO: begin
        lg_start = 1'b1;
        lg_x     = n_q;
      end
      S_RD:  we = 1'b1;
      S_CHK: lg_start = keep;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[ra];
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      fwd_vld_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      bin_q     <= '0;
      n_q       <= '0;
      ovf_q     <= 1'b0;
      qcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fwd_vld_q <= we;
      s1_vld_q  <= pop_o && q_entry_i.counted;
      if ((state_q == S_CLR) || (state_q == S_ADD) ||
          ((state_q == S_CHK) && !keep)) begin
        bin_q <= bin_q + 1'b1;
      end else if ((state_q == S_LN_WT) && lg_done) begin
        bin_q <= '0;
      end
      if (pop_o) begin
        if (q_entry_i.counted) begin
          n_q <= n_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (load) begin
        n_q   <= '0;
        ovf_q <= 1'b0;
      end
      if (state_q == S_DIV) begin
        qcnt_q <= qcnt_q + 1'b1;
      end else begin
        qcnt_q <= '0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= wa;
    fwd_data_q <= wd;
    s1_addr_q  <= q_entry_i.pixel;
    if (state_q == S_CHK) begin
      c_q <= rd_q;
    end
    if ((state_q == S_LN_WT) && lg_done) begin
      ln_q  <= lg_res;
      tot_q <= '0;
    end
    if ((state_q == S_LG_WT) && lg_done) begin
      diff_q <= ln_q - lg_res;
    end
    if (state_q == S_MUL) begin
      prod_q <= PW'(c_q) * PW'(diff_q);
    end
    if (state_q == S_ADD) begin
      tot_q <= tot_q + TW'(prod_q);
    end
    if (state_q == S_DVI) begin
      rem_q <= tot_q + (TW'(n_q) << 3);
      dsh_q <= TW'(n_q) << 21;
      quo_q <= '0;
    end
    if (state_q == S_DIV) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
    if (load) begin
      ent_q     <= (quo_q > QUO_W'(Q15_ONE)) ? ENT_W'(Q15_ONE) : quo_q[ENT_W-1:0];
      tot_out_q <= n_ext[TOT_W-1:0];
      ovf_out_q <= ovf_q;
    end
  end

  a_log_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lg_done |-> ((state_q == S_LN_WT) || (state_q == S_LG_WT)))
    else $error("log unit finished outside a wait state");

  a_pipe_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> !s1_vld_q)
    else $error("bin pass started with an update in flight");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && !out_vld_q) |=> out_vld_q)
    else $error("result not loaded into empty output register");

endmodule

/* dv/histogram_entropy_core_tb.sv */
module histogram_entropy_core_tb;
  import hec_pkg::*;

  typedef struct {
    logic [ENT_W-1:0] entropy_norm;
    logic [TOT_W-1:0] pixel_total;
    logic             count_overflow;
  } region_result_t;

  class entropy_scoreboard;
    int unsigned    bin_hist[NUM_BINS];
    int unsigned    pixel_count;
    bit             overflow_flag;
    region_result_t pending_regions[$];
    int unsigned    error_count;
    int unsigned    region_count;

    function void clear_region();
      foreach (bin_hist[b]) bin_hist[b] = 0;
      pixel_count   = 0;
      overflow_flag = 0;
    endfunction

    function longint unsigned log2_fix(longint unsigned x);
      longint unsigned e;
      longint unsigned t;
      longint unsigned m;
      longint unsigned frac;
      e = 0;
      t = x;
      frac = 0;
      if (x == 0) return 0;
      while (t > 1) begin
        t = t >> 1;
        e++;
      end
      m = x << (30 - e);
      for (int i = 0; i < FRAC_W; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return (e << FRAC_W) | frac;
    endfunction

    function longint unsigned region_entropy(longint unsigned n);
      longint unsigned acc;
      longint unsigned ln;
      longint unsigned q;
      acc = 0;
      ln = log2_fix(n);
      for (int b = 0; b < NUM_BINS; b++) begin
        longint unsigned c;
        c = bin_hist[b];
        if (c != 0 && c * SHARE_DIV > n) acc += c * (ln - log2_fix(c));
      end
      q = (acc + n * 8) / (n * 16);
      if (q > Q15_ONE) q = Q15_ONE;
      return q;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic last);
      region_result_t r;
      if (pixel_count < MAX_PIXELS) begin
        bin_hist[pix]++;
        pixel_count++;
      end else begin
        overflow_flag = 1;
      end
      if (last) begin
        r.entropy_norm   = ENT_W'(region_entropy(pixel_count));
        r.pixel_total    = TOT_W'(pixel_count);
        r.count_overflow = overflow_flag;
        pending_regions.insert(pending_regions.size(), r);
        clear_region();
      end
    endfunction

    function void check_result(region_result_t got);
      region_result_t want;
      region_count++;
      if (pending_regions.size() == 0) begin
        error_count++;
        $display("%0t unexpected result ent=%0d tot=%0d ovf=%0d", $time,
                 got.entropy_norm, got.pixel_total, got.count_overflow);
        return;
      end
      want = pending_regions.pop_front();
      if (got.entropy_norm !== want.entropy_norm) begin
        error_count++;
        $display("%0t entropy_norm expected %0d got %0d", $time, want.entropy_norm,
                 got.entropy_norm);
      end
      if (got.pixel_total !== want.pixel_total) begin
        error_count++;
        $display("%0t pixel_total expected %0d got %0d", $time, want.pixel_total,
                 got.pixel_total);
      end
      if (got.count_overflow !== want.count_overflow) begin
        error_count++;
        $display("%0t count_overflow expected %0d got %0d", $time,
                 want.count_overflow, got.count_overflow);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  hec_pix_if pix_if ();
  hec_res_if res_if ();

  histogram_entropy_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if.sink),
    .res_o  (res_if.source)
  );

  entropy_scoreboard region_sb;
  int unsigned       pixels_sent;
  int unsigned       cycle_count;
  bit                stim_done;
  bit                hold_sink;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      region_sb.note_pixel(pix_if.pixel, pix_if.last_pixel);
      pixels_sent++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      region_result_t r;
      r.entropy_norm   = res_if.entropy_norm;
      r.pixel_total    = res_if.pixel_total;
      r.count_overflow = res_if.count_overflow;
      region_sb.check_result(r);
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] pix, logic last, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      pix_if.valid <= 0;
      @(negedge clk_i);
    end
    pix_if.valid      <= 1;
    pix_if.pixel      <= pix;
    pix_if.last_pixel <= last;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_region(int unsigned len, int unsigned mode, bit no_gap);
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] p;
    base = PIX_W'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: p = PIX_W'($urandom_range(0, 255));
        1: p = base;
        2: p = base + PIX_W'($urandom_range(0, 3));
        default: p = PIX_W'(i);
      endcase
      send_pixel(p, i == len - 1, no_gap);
    end
  endtask

  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        res_if.ready <= 0;
      end else begin
        stall = $urandom_range(0, 13);
        if ($urandom_range(0, 2) == 0) stall = 0;
        if (stall != 0) begin
          res_if.ready <= 0;
          repeat (stall) @(negedge clk_i);
        end
        res_if.ready <= 1;
        @(posedge clk_i);
        while (!(res_if.valid && res_if.ready)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned drain;
    region_sb         = new();
    region_sb.clear_region();
    pix_if.valid      = 0;
    pix_if.pixel      = 0;
    pix_if.last_pixel = 0;
    res_if.ready      = 0;
    hold_sink         = 0;
    rst_ni            = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_pixel(8'h00, 1, 0);
    send_pixel(8'hff, 1, 0);
    send_pixel(8'h00, 0, 0);
    send_pixel(8'hff, 1, 0);
    send_region(256, 3, 1);
    send_region(6, 1, 0);
    send_region(8, 2, 0);
    send_region(5, 0, 0);

    fork
      begin
        hold_sink = 1;
        repeat (3000) @(posedge clk_i);
        hold_sink = 0;
      end
      begin
        repeat (12) send_region(1 + $urandom_range(0, 3), $urandom_range(0, 2), 1);
        pix_if.valid <= 0;
      end
    join
    @(negedge clk_i);

    while (pixels_sent < 800) begin
      case ($urandom_range(0, 9))
        0: send_region(1, 0, 0);
        1: send_region($urandom_range(100, 400), $urandom_range(0, 3), 1);
        default: send_region($urandom_range(1, 20), $urandom_range(0, 3), 0);
      endcase
    end
    pix_if.valid <= 0;

    drain = 0;
    while (region_sb.pending_regions.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (300) @(posedge clk_i);
    $display("regions checked %0d, pixels sent %0d, with random gaps on both sides",
             region_sb.region_count, pixels_sent);
    $display("and one long output hold that backed up the pixel input");
    if (region_sb.error_count == 0 && region_sb.pending_regions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
